@@ rtl/core/efb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_pkg
// Shared types, register indexes and the CRC-32 byte update of the frame
// builder.
// ----------------------------------------------------------------------------
package efb_pkg;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_last;
   } efb_req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } efb_rsp_type;

   // classified beat as it sits in the queue between front and back
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_last;
      logic       frame_first;
   } efb_qent_type;

   typedef logic [1:0] efb_csr_idx_type;

   localparam efb_csr_idx_type CSR_DEST_MAC   = 2'd0;
   localparam efb_csr_idx_type CSR_SRC_MAC    = 2'd1;
   localparam efb_csr_idx_type CSR_ETHER_TYPE = 2'd2;

   localparam logic [47:0] MAC_RESET        = 48'h0;
   localparam logic [15:0] ETHER_TYPE_RESET = 16'h07FF;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [7:0] PRE_START = 8'hFB;
   localparam logic [7:0] PRE_BYTE  = 8'h55;
   localparam logic [7:0] PRE_SFD   = 8'hD5;
   localparam logic [7:0] FILL_BYTE = 8'h07;

   // reflected CRC-32 over one byte, LSB first
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                              input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'h0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ rtl/core/efb_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_queue
// Small circular queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module efb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  efb_pkg::efb_qent_type push_data,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output efb_pkg::efb_qent_type head
);
   import efb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   efb_qent_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

endmodule

@@ rtl/core/efb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_front
// Accepts payload beats and tags the one that opens a frame.
// ----------------------------------------------------------------------------
module efb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  efb_pkg::efb_req_type  req_payload,
   input  logic                  q_full,
   output logic                  q_push,
   output efb_pkg::efb_qent_type q_data
);
   import efb_pkg::*;

   logic in_frame_ff, in_frame_in;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_data.payload_byte = req_payload.payload_byte;
      q_data.payload_last = req_payload.payload_last;
      q_data.frame_first  = !in_frame_ff;
      in_frame_in         = in_frame_ff;
      if (q_push) begin
         in_frame_in = !req_payload.payload_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

@@ rtl/core/efb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_back
// Byte sequencer: header, payload, CRC and fill, one byte per cycle into the
// output register with the running CRC, unless stalled or awaiting a beat.
// ----------------------------------------------------------------------------
module efb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [47:0]           dest_mac,
   input  logic [47:0]           src_mac,
   input  logic [15:0]           ether_type,
   input  logic                  q_valid,
   input  efb_pkg::efb_qent_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output efb_pkg::efb_rsp_type  rsp_payload
);
   import efb_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_PAYLD,
      S_CRC,
      S_FILL
   } state_type;

   localparam logic [4:0] HDR_LAST = 5'd21;
   localparam logic [4:0] CRC_LAST = 5'd3;

   state_type   state_ff, state_in;
   logic [4:0]  idx_ff, idx_in;
   logic [31:0] crc_ff, crc_in;
   logic [1:0]  len_ff, len_in;
   logic [1:0]  fill_ff, fill_in;
   logic        rsp_valid_ff, rsp_valid_in;
   efb_rsp_type rsp_ff, rsp_in;

   logic        advance;
   logic [7:0]  hdr_byte;
   logic [31:0] hdr_crc;
   logic [31:0] pay_crc;
   logic [1:0]  pay_len;

   function automatic logic [7:0] header_byte(input logic [4:0]  idx,
                                              input logic [47:0] dmac,
                                              input logic [47:0] smac,
                                              input logic [15:0] etype);
      logic [7:0] b;
      unique case (idx)
         5'd0:    b = PRE_START;
         5'd7:    b = PRE_SFD;
         5'd8:    b = dmac[47:40];
         5'd9:    b = dmac[39:32];
         5'd10:   b = dmac[31:24];
         5'd11:   b = dmac[23:16];
         5'd12:   b = dmac[15:8];
         5'd13:   b = dmac[7:0];
         5'd14:   b = smac[47:40];
         5'd15:   b = smac[39:32];
         5'd16:   b = smac[31:24];
         5'd17:   b = smac[23:16];
         5'd18:   b = smac[15:8];
         5'd19:   b = smac[7:0];
         5'd20:   b = etype[7:0];
         5'd21:   b = etype[15:8];
         default: b = PRE_BYTE;
      endcase
      return b;
   endfunction

   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign hdr_byte = header_byte(idx_ff, dest_mac, src_mac, ether_type);
   assign hdr_crc  = crc32_byte(crc_ff, hdr_byte);
   assign pay_crc  = crc32_byte(crc_ff, q_head.payload_byte);
   assign pay_len  = len_ff + 2'd1;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      len_in       = len_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      if (advance) begin
         rsp_valid_in     = 1'b0;
         rsp_in.frame_end = 1'b0;
         unique case (state_ff)
            S_IDLE, S_PAYLD: begin
               if (q_valid) begin
                  rsp_valid_in = 1'b1;
                  if (state_ff == S_IDLE && q_head.frame_first) begin
                     rsp_in.frame_byte = PRE_START;
                     crc_in            = crc32_byte(CRC_INIT, PRE_START);
                     len_in            = 2'd1;
                     idx_in            = 5'd1;
                     state_in          = S_HEAD;
                  end else begin
                     rsp_in.frame_byte = q_head.payload_byte;
                     q_pop             = 1'b1;
                     if (q_head.payload_last) begin
                        crc_in   = ~pay_crc;
                        fill_in  = 2'd0 - pay_len;
                        idx_in   = '0;
                        state_in = S_CRC;
                     end else begin
                        crc_in   = pay_crc;
                        len_in   = pay_len;
                        state_in = S_IDLE;
                     end
                  end
               end
            end
            S_HEAD: begin
               rsp_valid_in      = 1'b1;
               rsp_in.frame_byte = hdr_byte;
               crc_in            = hdr_crc;
               len_in            = len_ff + 2'd1;
               idx_in            = idx_ff + 5'd1;
               if (idx_ff == HDR_LAST) begin
                  state_in = S_PAYLD;
               end
            end
            S_CRC: begin
               // crc_ff already holds the inverted CRC, shifted out LSB first
               rsp_valid_in      = 1'b1;
               rsp_in.frame_byte = crc_ff[7:0];
               crc_in            = {8'h0, crc_ff[31:8]};
               idx_in            = idx_ff + 5'd1;
               if (idx_ff == CRC_LAST) begin
                  rsp_in.frame_end = (fill_ff == 2'd0);
                  state_in         = (fill_ff == 2'd0) ? S_IDLE : S_FILL;
               end
            end
            S_FILL: begin
               rsp_valid_in      = 1'b1;
               rsp_in.frame_byte = FILL_BYTE;
               rsp_in.frame_end  = (fill_ff == 2'd1);
               fill_in           = fill_ff - 2'd1;
               if (fill_ff == 2'd1) begin
                  state_in = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         crc_ff       <= CRC_INIT;
         len_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/core/ethernet_frame_builder_unit.sv @@
`timescale 1ns / 1ps
// A beat is registered in the queue, then its first byte in the output register.
// Throughput: one byte per unstalled cycle; a frame's first beat yields 22 header
// bytes before its payload byte, a last beat adds 4 CRC bytes and 0-3 fill bytes.
// Mid-frame beats pass one per unstalled cycle; the back sequencer sets the rate.
// Reset (synchronous): queue empty, no frame open, registers to their defaults.
// ----------------------------------------------------------------------------
// ethernet_frame_builder_unit
// Byte-serial frame builder: preamble, addresses, type, payload, CRC-32, fill.
// ----------------------------------------------------------------------------
module ethernet_frame_builder_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  efb_pkg::efb_req_type     req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output efb_pkg::efb_rsp_type     rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  efb_pkg::efb_csr_idx_type csr_index,
   input  logic [47:0]              csr_wdata
);
   import efb_pkg::*;

   logic [47:0] dest_mac_ff;
   logic [47:0] src_mac_ff;
   logic [15:0] ether_type_ff;

   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_valid;
   efb_qent_type q_data;
   efb_qent_type q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_mac_ff   <= MAC_RESET;
         src_mac_ff    <= MAC_RESET;
         ether_type_ff <= ETHER_TYPE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEST_MAC:   dest_mac_ff   <= csr_wdata;
            CSR_SRC_MAC:    src_mac_ff    <= csr_wdata;
            CSR_ETHER_TYPE: ether_type_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   efb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   efb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (q_head)
   );

   efb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .dest_mac    (dest_mac_ff),
      .src_mac     (src_mac_ff),
      .ether_type  (ether_type_ff),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ sim/efb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_checker
// Watches the payload, frame and register channels of the frame builder,
// predicts every outgoing frame byte from the accepted payload beats and the
// register writes it has seen, and compares each frame beat in order.
// ----------------------------------------------------------------------------
module efb_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  efb_pkg::efb_req_type     req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  efb_pkg::efb_rsp_type     rsp_payload,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  efb_pkg::efb_csr_idx_type csr_index,
   input  logic [47:0]              csr_wdata,
   output int                       fail_count,
   output int                       pending_count
);
   import efb_pkg::*;

   logic [47:0]  dest_addr;
   logic [47:0]  src_addr;
   logic [15:0]  type_field;
   logic         open_frame;
   logic [31:0]  fcs_acc;
   logic [1:0]   len_mod4;
   efb_rsp_type  bytes_due[$];
   int           mismatches;

   // reflected CRC-32, one data bit folded in per shift
   function automatic logic [31:0] fcs_next(input logic [31:0] c, input logic [7:0] d);
      logic [31:0] r;
      logic        fb;
      r = c;
      for (int k = 0; k < 8; k++) begin
         fb = r[0] ^ d[k];
         r  = r >> 1;
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic fin, input logic covered);
      efb_rsp_type e;
      if (covered) fcs_acc = fcs_next(fcs_acc, b);
      e.frame_byte = b;
      e.frame_end  = fin;
      bytes_due.insert(bytes_due.size(), e);
      len_mod4 = len_mod4 + 2'd1;
   endtask

   task automatic predict_frame_bytes(input efb_req_type beat);
      logic [31:0] fcs;
      logic [1:0]  pad;
      if (!open_frame) begin
         fcs_acc  = CRC_INIT;
         len_mod4 = 2'd0;
         push_byte(PRE_START, 1'b0, 1'b1);
         for (int k = 0; k < 6; k++) push_byte(PRE_BYTE, 1'b0, 1'b1);
         push_byte(PRE_SFD, 1'b0, 1'b1);
         for (int k = 5; k >= 0; k--) push_byte(dest_addr[8*k +: 8], 1'b0, 1'b1);
         for (int k = 5; k >= 0; k--) push_byte(src_addr[8*k +: 8], 1'b0, 1'b1);
         push_byte(type_field[7:0], 1'b0, 1'b1);
         push_byte(type_field[15:8], 1'b0, 1'b1);
         open_frame = 1'b1;
      end
      push_byte(beat.payload_byte, 1'b0, 1'b1);
      if (beat.payload_last) begin
         fcs = ~fcs_acc;
         // FCS keeps length mod 4, so the pad count is fixed here
         pad = 2'd0 - len_mod4;
         for (int k = 0; k < 4; k++) push_byte(fcs[8*k +: 8], (k == 3) && (pad == 2'd0), 1'b0);
         while (pad != 2'd0) begin
            push_byte(FILL_BYTE, pad == 2'd1, 1'b0);
            pad = pad - 2'd1;
         end
         open_frame = 1'b0;
         fcs_acc    = CRC_INIT;
         len_mod4   = 2'd0;
      end
   endtask

   task automatic check_frame_byte(input efb_rsp_type got);
      efb_rsp_type want;
      if (bytes_due.size() == 0) begin
         $error("unexpected frame beat: frame_byte %h frame_end %b",
                got.frame_byte, got.frame_end);
         mismatches++;
      end else begin
         want = bytes_due.pop_front();
         if (got.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %h, actual %h", want.frame_byte, got.frame_byte);
            mismatches++;
         end
         if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, actual %b", want.frame_end, got.frame_end);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         dest_addr  = MAC_RESET;
         src_addr   = MAC_RESET;
         type_field = ETHER_TYPE_RESET;
         open_frame = 1'b0;
         fcs_acc    = CRC_INIT;
         len_mod4   = 2'd0;
         bytes_due.delete();
         mismatches = 0;
      end else begin
         // compare before predicting so a stray beat never meets a fresh entry
         if (rsp_valid && !rsp_stall) check_frame_byte(rsp_payload);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEST_MAC:   dest_addr = csr_wdata;
               CSR_SRC_MAC:    src_addr = csr_wdata;
               CSR_ETHER_TYPE: type_field = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_frame_bytes(req_payload);
      end
      fail_count    <= mismatches;
      pending_count <= bytes_due.size();
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the frame builder: directed frames at the register and fill
// corners, then random frames under changing addresses and type, with random
// idling on both channels, a long receiver hold-off and a watchdog.
// ----------------------------------------------------------------------------
module tb;
   import efb_pkg::*;

   localparam efb_csr_idx_type CSR_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int RANDOM_BEATS   = 270;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   efb_req_type     req_payload = '0;
   logic            rsp_stall   = 1'b0;
   logic            csr_valid   = 1'b0;
   efb_csr_idx_type csr_index   = CSR_DEST_MAC;
   logic [47:0]     csr_wdata   = '0;
   logic            req_stall;
   logic            rsp_valid;
   efb_rsp_type     rsp_payload;
   logic            csr_ready;

   logic            steady      = 1'b0;
   logic            squeeze_req = 1'b0;
   int              fail_count;
   int              pending_count;
   int              beats_sent  = 0;
   int              quiet       = 0;

   always #5 clock = ~clock;

   ethernet_frame_builder_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   efb_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   function automatic bit take_gap();
      return !steady && ($urandom_range(99) < 30);
   endfunction

   function automatic logic [47:0] pick_word();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      case ($urandom_range(3))
         0: w = '0;
         1: w = '1;
         default: ;
      endcase
      return w[47:0];
   endfunction

   // valid stays high on return; the next call lowers it only for a gap
   task automatic send_beat(input logic [7:0] b, input logic last);
      if (take_gap()) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (take_gap());
      end
      req_valid   <= 1'b1;
      req_payload <= efb_req_type'{payload_byte: b, payload_last: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input efb_csr_idx_type idx, input logic [47:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_setting();
      csr_write(CSR_DEST_MAC, pick_word());
      csr_write(CSR_SRC_MAC, pick_word());
      csr_write(CSR_ETHER_TYPE, pick_word());
      if ($urandom_range(3) == 0) csr_write(CSR_UNUSED, pick_word());
   endtask

   // receiver: random stall, plus one long hold-off on request
   initial begin
      bit squeeze_done;
      squeeze_done = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_req && !squeeze_done) begin
            rsp_stall    <= 1'b1;
            squeeze_done = 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= take_gap();
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int phase;
      int len;
      int nframes;
      int directed;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults straight out of reset
      send_beat(8'h00, 1'b1);
      wait_idle();
      // write to the unused index must change nothing
      csr_write(CSR_UNUSED, '1);
      send_beat(8'h5A, 1'b1);
      wait_idle();

      // all ones; type write carries extra upper bits; lengths 1..4 hit every pad count
      csr_write(CSR_DEST_MAC, '1);
      csr_write(CSR_SRC_MAC, '1);
      csr_write(CSR_ETHER_TYPE, '1);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h80, 1'b0);
      send_beat(8'h01, 1'b0);
      send_beat(8'h7F, 1'b1);
      send_beat(8'hFE, 1'b0);
      send_beat(8'h55, 1'b0);
      send_beat(8'hAA, 1'b0);
      send_beat(8'hFF, 1'b1);
      wait_idle();

      csr_write(CSR_DEST_MAC, '0);
      csr_write(CSR_SRC_MAC, 48'hAAAA_5555_AAAA);
      csr_write(CSR_ETHER_TYPE, 48'h5555_5555_0000);
      send_beat(8'h0F, 1'b0);
      send_beat(8'hF0, 1'b1);
      wait_idle();

      directed = beats_sent;
      phase    = 0;
      while (beats_sent < directed + RANDOM_BEATS) begin
         program_setting();
         if (phase == 1) squeeze_req <= 1'b1;
         steady  <= (phase == 3);
         nframes = $urandom_range(6, 2);
         repeat (nframes) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
            for (int k = 0; k < len; k++) send_beat(8'($urandom_range(255)), k == len - 1);
         end
         wait_idle();
         phase++;
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
